// ----- sv/skst_pkg.sv -----
// Shared types and constants for the scancode key state tracker.
// Holds opcodes, the command and status structs, and the set-1 character map.
// No dependencies.
package skst_pkg;

  localparam logic [2:0] OP_SCANCODE = 3'd0;
  localparam logic [2:0] OP_PRESSED  = 3'd1;
  localparam logic [2:0] OP_HIT      = 3'd2;
  localparam logic [2:0] OP_GETCHAR  = 3'd3;
  localparam logic [2:0] OP_CLEAR    = 3'd4;

  localparam int CODE_W      = 8;
  localparam int KEY_W       = 7;
  localparam int CHAR_W      = 7;
  localparam int CHUNK_W     = 16;
  localparam int CHUNK_IDX_W = 4;

  localparam logic [CODE_W-1:0] KEY_MASK  = 8'h7F;
  localparam logic [CODE_W-1:0] BREAK_BIT = 8'h80;

  typedef struct packed {
    logic exec;
    logic scan;
    logic finish;
  } skst_cmd_t;

  typedef struct packed {
    logic chunk_hit;
  } skst_sts_t;

  function automatic logic [CHAR_W-1:0] char_of(input logic [KEY_W-1:0] code);
    logic [CHAR_W-1:0] ch;
    unique case (code)
      7'h02: ch = 7'h31;
      7'h03: ch = 7'h32;
      7'h04: ch = 7'h33;
      7'h05: ch = 7'h34;
      7'h06: ch = 7'h35;
      7'h07: ch = 7'h36;
      7'h08: ch = 7'h37;
      7'h09: ch = 7'h38;
      7'h0A: ch = 7'h39;
      7'h0B: ch = 7'h30;
      7'h10: ch = 7'h51;
      7'h11: ch = 7'h57;
      7'h12: ch = 7'h45;
      7'h13: ch = 7'h52;
      7'h14: ch = 7'h54;
      7'h15: ch = 7'h59;
      7'h16: ch = 7'h55;
      7'h17: ch = 7'h49;
      7'h18: ch = 7'h4F;
      7'h19: ch = 7'h50;
      7'h1E: ch = 7'h41;
      7'h1F: ch = 7'h53;
      7'h20: ch = 7'h44;
      7'h21: ch = 7'h46;
      7'h22: ch = 7'h47;
      7'h23: ch = 7'h48;
      7'h24: ch = 7'h4A;
      7'h25: ch = 7'h4B;
      7'h26: ch = 7'h4C;
      7'h2C: ch = 7'h5A;
      7'h2D: ch = 7'h58;
      7'h2E: ch = 7'h43;
      7'h2F: ch = 7'h56;
      7'h30: ch = 7'h42;
      7'h31: ch = 7'h4E;
      7'h32: ch = 7'h4D;
      7'h39: ch = 7'h20;
      default: ch = '0;
    endcase
    return ch;
  endfunction

endpackage

// ----- sv/skst_ctrl.sv -----
// Controller of the scancode key state tracker.
// Decides when an item executes and steps the get-char scan over key chunks.
// Depends on skst_pkg.
module skst_ctrl #(
  parameter int NUM_KEYS = 128,
  localparam int NumChunks = (NUM_KEYS + skst_pkg::CHUNK_W - 1) / skst_pkg::CHUNK_W,
  localparam int ChunkW = (NumChunks > 1) ? $clog2(NumChunks) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [2:0]            opcode_i,
  input  skst_pkg::skst_sts_t   sts_i,
  output skst_pkg::skst_cmd_t   cmd_o,
  output logic [ChunkW-1:0]     chunk_o,
  output logic                  busy_o
);
  import skst_pkg::*;

  typedef enum logic {ST_IDLE, ST_SCAN} state_e;

  state_e              state_q;
  logic [ChunkW-1:0]   chunk_q;

  always_comb begin
    cmd_o.exec   = (state_q == ST_IDLE) && start_i && (opcode_i != OP_GETCHAR);
    cmd_o.scan   = (state_q == ST_SCAN);
    cmd_o.finish = cmd_o.scan && (sts_i.chunk_hit || (chunk_q == ChunkW'(NumChunks - 1)));
  end

  assign chunk_o = chunk_q;
  assign busy_o  = (state_q == ST_SCAN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      chunk_q <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (start_i && (opcode_i == OP_GETCHAR)) begin
            state_q <= ST_SCAN;
            chunk_q <= '0;
          end
        end
        ST_SCAN: begin
          if (cmd_o.finish) begin
            state_q <= ST_IDLE;
          end else begin
            chunk_q <= chunk_q + 1'b1;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- sv/skst_datapath.sv -----
// Datapath of the scancode key state tracker.
// Holds the down and edge flag vectors, the chunk scan and the result registers.
// Depends on skst_pkg.
module skst_datapath #(
  parameter int NUM_KEYS = 128,
  localparam int NumChunks = (NUM_KEYS + skst_pkg::CHUNK_W - 1) / skst_pkg::CHUNK_W,
  localparam int ChunkW = (NumChunks > 1) ? $clog2(NumChunks) : 1,
  localparam int KeyIdxW = $clog2(NUM_KEYS)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  skst_pkg::skst_cmd_t         cmd_i,
  input  logic [2:0]                  opcode_i,
  input  logic [skst_pkg::CODE_W-1:0] key_code_i,
  input  logic [ChunkW-1:0]           chunk_i,
  output skst_pkg::skst_sts_t         sts_o,
  output logic                        done_o,
  output logic                        key_down_o,
  output logic                        edge_taken_o,
  output logic [skst_pkg::CHAR_W-1:0] char_out_o
);
  import skst_pkg::*;

  localparam int PosW = ChunkW + CHUNK_IDX_W;
  localparam int PadW = 1 << PosW;

  logic [NUM_KEYS-1:0]    down_q, down_d;
  logic [NUM_KEYS-1:0]    edge_q, edge_d;
  logic                   done_q, done_d;
  logic                   key_down_q, key_down_d;
  logic                   edge_taken_q, edge_taken_d;
  logic [CHAR_W-1:0]      char_q, char_d;

  logic [KEY_W-1:0]       idx;
  logic                   idx_ok;
  logic                   brk;
  logic [KeyIdxW-1:0]     k;
  logic [PadW-1:0]        edge_pad;
  logic [CHUNK_W-1:0]     chunk_edges;
  logic [CHUNK_W-1:0]     chunk_mapped;
  logic [CHUNK_W-1:0]     chunk_hits;
  logic [CHUNK_IDX_W-1:0] sel;
  logic [PosW-1:0]        pos;

  assign idx    = KEY_W'(key_code_i & KEY_MASK);
  assign brk    = |(key_code_i & BREAK_BIT);
  assign idx_ok = (CODE_W'(idx) < CODE_W'(NUM_KEYS));
  assign k      = idx[KeyIdxW-1:0];

  assign edge_pad    = PadW'(edge_q);
  assign chunk_edges = edge_pad[chunk_i*CHUNK_W +: CHUNK_W];

  always_comb begin
    for (int j = 0; j < CHUNK_W; j++) begin
      chunk_mapped[j] = (char_of(KEY_W'({chunk_i, CHUNK_IDX_W'(j)})) != '0);
    end
  end

  assign chunk_hits      = chunk_edges & chunk_mapped;
  assign sts_o.chunk_hit = |chunk_hits;

  always_comb begin
    sel = '0;
    for (int j = CHUNK_W - 1; j >= 0; j--) begin
      if (chunk_hits[j]) begin
        sel = CHUNK_IDX_W'(j);
      end
    end
  end

  assign pos = {chunk_i, sel};

  always_comb begin
    logic [PadW-1:0] pad_d;
    pad_d        = edge_pad;
    down_d       = down_q;
    edge_d       = edge_q;
    key_down_d   = 1'b0;
    edge_taken_d = 1'b0;
    char_d       = '0;
    done_d       = cmd_i.exec || cmd_i.finish;
    if (cmd_i.exec) begin
      case (opcode_i)
        OP_SCANCODE: begin
          if (idx_ok) begin
            if (brk) begin
              down_d[k] = 1'b0;
            end else begin
              if (!down_q[k]) begin
                edge_d[k] = 1'b1;
              end
              down_d[k] = 1'b1;
            end
          end
        end
        OP_PRESSED: begin
          key_down_d = idx_ok && down_q[k];
        end
        OP_HIT: begin
          if (idx_ok && edge_q[k]) begin
            edge_d[k]    = 1'b0;
            edge_taken_d = 1'b1;
          end
        end
        OP_CLEAR: begin
          down_d = '0;
          edge_d = '0;
        end
        default: ;
      endcase
    end else if (cmd_i.scan && sts_o.chunk_hit) begin
      pad_d[pos] = 1'b0;
      edge_d     = pad_d[NUM_KEYS-1:0];
      char_d     = char_of(KEY_W'(pos));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      down_q <= '0;
      edge_q <= '0;
      done_q <= 1'b0;
    end else begin
      down_q <= down_d;
      edge_q <= edge_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_down_q   <= key_down_d;
    edge_taken_q <= edge_taken_d;
    char_q       <= char_d;
  end

  assign done_o       = done_q;
  assign key_down_o   = key_down_q;
  assign edge_taken_o = edge_taken_q;
  assign char_out_o   = char_q;

endmodule

// ----- sv/scancode_key_state_tracker_core.sv -----
// Top level of the scancode key state tracker: controller plus datapath.
// Key update, pressed query, hit query, clear and reserved opcodes: result in the cycle after the item is taken.
// Such items may be started back to back, one per cycle.
// Get-char scans 16 keys per cycle while busy; the result follows in the cycle after the scan ends.
// The receiver cannot stall; each result shows for one cycle with done_o high.
// Reset clears all down and edge flags at once; the block takes items right after reset.
module scancode_key_state_tracker_core #(
  parameter int NUM_KEYS = 128
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [2:0]                  opcode_i,
  input  logic [skst_pkg::CODE_W-1:0] key_code_i,
  output logic                        done_o,
  output logic                        key_down_o,
  output logic                        edge_taken_o,
  output logic [skst_pkg::CHAR_W-1:0] char_out_o
);
  import skst_pkg::*;

  localparam int NumChunks = (NUM_KEYS + CHUNK_W - 1) / CHUNK_W;
  localparam int ChunkW = (NumChunks > 1) ? $clog2(NumChunks) : 1;

  skst_cmd_t         cmd;
  skst_sts_t         sts;
  logic [ChunkW-1:0] chunk;

  skst_ctrl #(
    .NUM_KEYS(NUM_KEYS)
  ) u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .opcode_i(opcode_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .chunk_o (chunk),
    .busy_o  (busy)
  );

  skst_datapath #(
    .NUM_KEYS(NUM_KEYS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .opcode_i    (opcode_i),
    .key_code_i  (key_code_i),
    .chunk_i     (chunk),
    .sts_o       (sts),
    .done_o      (done_o),
    .key_down_o  (key_down_o),
    .edge_taken_o(edge_taken_o),
    .char_out_o  (char_out_o)
  );

endmodule

// ----- sv/skst_checker.sv -----
// Port-level checks for the scancode key state tracker.
// Bound to scancode_key_state_tracker_core; depends on skst_pkg.
module skst_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start,
  input logic                        busy,
  input logic [2:0]                  opcode_i,
  input logic                        done_o,
  input logic                        key_down_o,
  input logic                        edge_taken_o,
  input logic [skst_pkg::CHAR_W-1:0] char_out_o
);
  import skst_pkg::*;

  a_quick_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (opcode_i != OP_GETCHAR)) |=> done_o)
    else $error("Item other than get-char gave no result in the next cycle.");

  a_one_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($countones({key_down_o, edge_taken_o, |char_out_o}) <= 1))
    else $error("Result carries more than one kind of answer.");

  a_busy_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start && (opcode_i == OP_GETCHAR)))
    else $error("Busy rose without a get-char item.");

  a_scan_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("Scan ended without a result.");

  a_char_from_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (char_out_o != '0)) |-> $past(busy))
    else $error("Character returned without a scan.");

endmodule

bind scancode_key_state_tracker_core skst_checker u_skst_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .opcode_i    (opcode_i),
  .done_o      (done_o),
  .key_down_o  (key_down_o),
  .edge_taken_o(edge_taken_o),
  .char_out_o  (char_out_o)
);

// ----- tb/sv/tb_scancode_key_state_tracker_core.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for scancode_key_state_tracker_core: a queue-fed driver, a
// key-table predictor and a strobe monitor compare every result field by field.
// Depends on skst_pkg and scancode_key_state_tracker_core.
module tb_scancode_key_state_tracker_core;
  import skst_pkg::*;

  localparam int NUM_KEYS = 128;
  localparam int N_ITEMS = 1475;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic [2:0] OP_RSVD_LO = 3'd5;
  localparam logic [2:0] OP_RSVD_MID = 3'd6;
  localparam logic [2:0] OP_RSVD_HI = 3'd7;

  typedef struct packed {
    logic [2:0]        op;
    logic [CODE_W-1:0] code;
  } key_cmd_t;

  typedef struct packed {
    logic              key_down;
    logic              edge_taken;
    logic [CHAR_W-1:0] char_out;
  } key_result_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic [2:0]        opcode_i = OP_SCANCODE;
  logic [CODE_W-1:0] key_code_i = '0;
  logic              busy;
  logic              done_o;
  logic              key_down_o;
  logic              edge_taken_o;
  logic [CHAR_W-1:0] char_out_o;

  key_cmd_t    cmd_q[$];
  key_result_t key_results_q[$];
  logic        down_st[NUM_KEYS];
  logic        edge_st[NUM_KEYS];
  logic [7:0]  char_tbl[128];
  int          err_cnt = 0;
  int          n_taken = 0;
  int          idle_cycles = 0;

  scancode_key_state_tracker_core #(
    .NUM_KEYS(NUM_KEYS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .opcode_i    (opcode_i),
    .key_code_i  (key_code_i),
    .done_o      (done_o),
    .key_down_o  (key_down_o),
    .edge_taken_o(edge_taken_o),
    .char_out_o  (char_out_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic key_result_t apply_key_cmd(key_cmd_t c);
    key_result_t r;
    int idx;
    r = '0;
    idx = int'(c.code & KEY_MASK);
    case (c.op)
      OP_SCANCODE: begin
        if (idx < NUM_KEYS) begin
          if ((c.code & BREAK_BIT) != '0) begin
            down_st[idx] = 1'b0;
          end else begin
            if (!down_st[idx]) edge_st[idx] = 1'b1;
            down_st[idx] = 1'b1;
          end
        end
      end
      OP_PRESSED: begin
        if (idx < NUM_KEYS) r.key_down = down_st[idx];
      end
      OP_HIT: begin
        if (idx < NUM_KEYS && edge_st[idx]) begin
          edge_st[idx] = 1'b0;
          r.edge_taken = 1'b1;
        end
      end
      OP_GETCHAR: begin
        for (int i = 0; i < NUM_KEYS && i < 128; i++) begin
          if (edge_st[i] && char_tbl[i] != 8'd0) begin
            edge_st[i] = 1'b0;
            r.char_out = char_tbl[i][CHAR_W-1:0];
            break;
          end
        end
      end
      OP_CLEAR: begin
        for (int i = 0; i < NUM_KEYS; i++) begin
          down_st[i] = 1'b0;
          edge_st[i] = 1'b0;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [CODE_W-1:0] pick_key(bit want_char);
    logic [CODE_W-1:0] k;
    do begin
      k = CODE_W'($urandom_range(0, NUM_KEYS - 1));
    end while (want_char && char_tbl[k] == 8'd0);
    return k;
  endfunction

  // Driver: holds an item until it is taken, then pops the next one or idles.
  always @(posedge clk_i) begin
    logic took;
    logic quiet;
    key_cmd_t nxt;
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      took = start && !busy;
      if (took) begin
        key_results_q.push_back(apply_key_cmd('{op: opcode_i, code: key_code_i}));
        n_taken++;
      end
      if (!start || took) begin
        quiet = (n_taken >= 500 && n_taken < 800);
        if (cmd_q.size() > 0 && (quiet || $urandom_range(0, 99) >= 26)) begin
          nxt = cmd_q.pop_front();
          start <= 1'b1;
          opcode_i <= nxt.op;
          key_code_i <= nxt.code;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed result is matched against the oldest prediction.
  always @(posedge clk_i) begin
    key_result_t exp_r;
    if (rst_ni && done_o) begin
      if (key_results_q.size() == 0) begin
        $error("unexpected result: key_down %0d edge_taken %0d char_out %0d",
               key_down_o, edge_taken_o, char_out_o);
        err_cnt++;
      end else begin
        exp_r = key_results_q.pop_front();
        if (key_down_o !== exp_r.key_down) begin
          $error("key_down mismatch: expected %0d, got %0d", exp_r.key_down, key_down_o);
          err_cnt++;
        end
        if (edge_taken_o !== exp_r.edge_taken) begin
          $error("edge_taken mismatch: expected %0d, got %0d",
                 exp_r.edge_taken, edge_taken_o);
          err_cnt++;
        end
        if (char_out_o !== exp_r.char_out) begin
          $error("char_out mismatch: expected %0h, got %0h", exp_r.char_out, char_out_o);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    string digits;
    string top_row;
    string mid_row;
    string low_row;
    logic [CODE_W-1:0] k;
    int r;

    digits = "1234567890";
    top_row = "QWERTYUIOP";
    mid_row = "ASDFGHJKL";
    low_row = "ZXCVBNM";
    for (int i = 0; i < 128; i++) char_tbl[i] = 8'd0;
    for (int i = 0; i < digits.len(); i++) char_tbl[8'h02 + i] = digits[i];
    for (int i = 0; i < top_row.len(); i++) char_tbl[8'h10 + i] = top_row[i];
    for (int i = 0; i < mid_row.len(); i++) char_tbl[8'h1E + i] = mid_row[i];
    for (int i = 0; i < low_row.len(); i++) char_tbl[8'h2C + i] = low_row[i];
    char_tbl[8'h39] = " ";
    for (int i = 0; i < NUM_KEYS; i++) begin
      down_st[i] = 1'b0;
      edge_st[i] = 1'b0;
    end

    // Directed part: make, typematic repeat, queries, keys without a character,
    // the index extremes, reserved opcodes and a clear.
    cmd_q.push_back('{OP_SCANCODE, 8'h10});
    cmd_q.push_back('{OP_SCANCODE, 8'h10});
    cmd_q.push_back('{OP_PRESSED, 8'h10});
    cmd_q.push_back('{OP_PRESSED, 8'h90});
    cmd_q.push_back('{OP_HIT, 8'h10});
    cmd_q.push_back('{OP_HIT, 8'h10});
    cmd_q.push_back('{OP_SCANCODE, 8'h1C});
    cmd_q.push_back('{OP_SCANCODE, 8'h39});
    cmd_q.push_back('{OP_SCANCODE, 8'h02});
    cmd_q.push_back('{OP_GETCHAR, 8'h00});
    cmd_q.push_back('{OP_GETCHAR, 8'hFF});
    cmd_q.push_back('{OP_GETCHAR, 8'h00});
    cmd_q.push_back('{OP_HIT, 8'h1C});
    cmd_q.push_back('{OP_SCANCODE, 8'h90});
    cmd_q.push_back('{OP_PRESSED, 8'h10});
    cmd_q.push_back('{OP_SCANCODE, 8'h7F});
    cmd_q.push_back('{OP_SCANCODE, 8'h00});
    cmd_q.push_back('{OP_PRESSED, 8'hFF});
    cmd_q.push_back('{OP_PRESSED, 8'h00});
    cmd_q.push_back('{OP_RSVD_LO, 8'hFF});
    cmd_q.push_back('{OP_RSVD_MID, 8'h55});
    cmd_q.push_back('{OP_RSVD_HI, 8'hAA});
    cmd_q.push_back('{OP_CLEAR, 8'h00});
    cmd_q.push_back('{OP_PRESSED, 8'h7F});
    cmd_q.push_back('{OP_HIT, 8'h00});

    // Random part: mostly make/hold/break sessions with queries in between.
    while (cmd_q.size() < N_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        k = pick_key($urandom_range(0, 99) < 70);
        cmd_q.push_back('{OP_SCANCODE, k});
        repeat ($urandom_range(0, 2)) cmd_q.push_back('{OP_SCANCODE, k});
        if ($urandom_range(0, 1)) begin
          cmd_q.push_back('{OP_PRESSED, k | (BREAK_BIT & CODE_W'($urandom_range(0, 255)))});
        end
        if ($urandom_range(0, 3) == 0) cmd_q.push_back('{OP_HIT, k});
        if ($urandom_range(0, 99) < 80) cmd_q.push_back('{OP_SCANCODE, k | BREAK_BIT});
      end else if (r < 80) begin
        cmd_q.push_back('{OP_GETCHAR, CODE_W'($urandom_range(0, 255))});
      end else if (r < 88) begin
        cmd_q.push_back('{$urandom_range(0, 1) ? OP_HIT : OP_PRESSED,
                          CODE_W'($urandom_range(0, 255))});
      end else if (r < 90) begin
        cmd_q.push_back('{3'($urandom_range(OP_RSVD_LO, OP_RSVD_HI)),
                          CODE_W'($urandom_range(0, 255))});
      end else if (r < 91) begin
        cmd_q.push_back('{OP_CLEAR, CODE_W'($urandom_range(0, 255))});
      end else begin
        cmd_q.push_back('{3'($urandom_range(OP_SCANCODE, OP_RSVD_HI)),
                          CODE_W'($urandom_range(0, 255))});
      end
    end

    while (cmd_q.size() > 0 || start || key_results_q.size() > 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (err_cnt == 0 && key_results_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/skst_pkg.sv
sv/skst_ctrl.sv
sv/skst_datapath.sv
sv/scancode_key_state_tracker_core.sv
sv/skst_checker.sv
tb/sv/tb_scancode_key_state_tracker_core.sv
